// ----- sv/psp_pkg.sv -----
// Shared types, Pauli code constants and lookup tables for the Pauli string product block.
// Used by psp_lane, psp_cmul, psp_merge and pauli_string_product_phase; no dependencies.
package psp_pkg;

   typedef logic [1:0] pauli_type;

   localparam pauli_type PAULI_I = 2'd0;
   localparam pauli_type PAULI_X = 2'd1;
   localparam pauli_type PAULI_Y = 2'd2;
   localparam pauli_type PAULI_Z = 2'd3;

   localparam int WORD_BITS = 64;
   localparam int MAX_LANES = 32;

   // product code, indexed by left*4 + right
   localparam pauli_type PROD_TABLE [16] = '{
      PAULI_I, PAULI_X, PAULI_Y, PAULI_Z,
      PAULI_X, PAULI_I, PAULI_Z, PAULI_Y,
      PAULI_Y, PAULI_Z, PAULI_I, PAULI_X,
      PAULI_Z, PAULI_Y, PAULI_X, PAULI_I
   };

   // exponent of i added by one lane, indexed by left*4 + right
   localparam logic [1:0] PHASE_TABLE [16] = '{
      2'd0, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd0, 2'd1, 2'd3,
      2'd0, 2'd3, 2'd0, 2'd1,
      2'd0, 2'd1, 2'd3, 2'd0
   };

   // load strobes of the three pipeline stages
   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
   } pipe_ctl_type;

   function automatic pauli_type pauli_product(input pauli_type left, input pauli_type right);
      return PROD_TABLE[{left, right}];
   endfunction

   function automatic logic [1:0] lane_phase(input pauli_type left, input pauli_type right);
      return PHASE_TABLE[{left, right}];
   endfunction

endpackage

// ----- sv/psp_lane.sv -----
// One qubit lane: product code, phase contribution and mismatch of a left/right code pair.
// Depends on psp_pkg for the product and phase tables.
module psp_lane (
   input  psp_pkg::pauli_type left_code,
   input  psp_pkg::pauli_type right_code,
   output psp_pkg::pauli_type prod_code,
   output logic [1:0]         phase,
   output logic               mismatch
);

   assign prod_code = psp_pkg::pauli_product(left_code, right_code);
   assign phase     = psp_pkg::lane_phase(left_code, right_code);
   assign mismatch  = (left_code != right_code);

endmodule

// ----- sv/psp_cmul.sv -----
// Complex coefficient multiplier: registered partial products, then round half up and clip.
// Depends on psp_pkg for the pipeline control struct.
module psp_cmul #(
   parameter int CW = 16
) (
   input  logic                   clock,
   input  psp_pkg::pipe_ctl_type  ctl,
   input  logic signed [CW-1:0]   a_re,
   input  logic signed [CW-1:0]   a_im,
   input  logic signed [CW-1:0]   b_re,
   input  logic signed [CW-1:0]   b_im,
   output logic signed [CW-1:0]   prod_re,
   output logic signed [CW-1:0]   prod_im,
   output logic                   prod_sat
);

   localparam int PW = 2 * CW;
   localparam int SW = 2 * CW + 2;
   localparam int FRAC = CW - 2;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC - 1);
   localparam logic signed [SW-1:0] MAX_V = (SW'(1) <<< (CW - 1)) - SW'(1);
   localparam logic signed [SW-1:0] MIN_V = -(SW'(1) <<< (CW - 1));

   logic signed [PW-1:0] ac_ff, bd_ff, ad_ff, bc_ff;
   logic signed [SW-1:0] sum_re, sum_im, rnd_re, rnd_im;
   logic signed [CW-1:0] clip_re, clip_im;
   logic                 sat_re, sat_im;
   logic signed [CW-1:0] re_ff, im_ff;
   logic                 sat_ff;

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         ac_ff <= a_re * b_re;
         bd_ff <= a_im * b_im;
         ad_ff <= a_re * b_im;
         bc_ff <= a_im * b_re;
      end
   end

   always_comb begin
      sum_re = SW'(ac_ff) - SW'(bd_ff);
      sum_im = SW'(ad_ff) + SW'(bc_ff);
      rnd_re = (sum_re + HALF) >>> FRAC;
      rnd_im = (sum_im + HALF) >>> FRAC;
      sat_re = (rnd_re > MAX_V) || (rnd_re < MIN_V);
      sat_im = (rnd_im > MAX_V) || (rnd_im < MIN_V);
      priority if (rnd_re > MAX_V) begin
         clip_re = MAX_V[CW-1:0];
      end else if (rnd_re < MIN_V) begin
         clip_re = MIN_V[CW-1:0];
      end else begin
         clip_re = rnd_re[CW-1:0];
      end
      priority if (rnd_im > MAX_V) begin
         clip_im = MAX_V[CW-1:0];
      end else if (rnd_im < MIN_V) begin
         clip_im = MIN_V[CW-1:0];
      end else begin
         clip_im = rnd_im[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         re_ff  <= clip_re;
         im_ff  <= clip_im;
         sat_ff <= sat_re | sat_im;
      end
   end

   assign prod_re  = re_ff;
   assign prod_im  = im_ff;
   assign prod_sat = sat_ff;

endmodule

// ----- sv/psp_merge.sv -----
// Merges the lane results: phase and equality reduction, then the running string state,
// the i^phase rotation and the result register. Depends on psp_pkg.
module psp_merge #(
   parameter int LANES = 32,
   parameter int CW    = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  psp_pkg::pipe_ctl_type      ctl,
   input  logic                       s1_first,
   input  logic                       s1_last,
   input  logic [2*LANES-1:0]         s1_prod,
   input  logic [2*LANES-1:0]         s1_phase,
   input  logic [LANES-1:0]           s1_mismatch,
   input  logic signed [CW-1:0]       coef_re,
   input  logic signed [CW-1:0]       coef_im,
   input  logic                       coef_sat,
   output logic [psp_pkg::WORD_BITS-1:0] out_prod,
   output logic                       out_last,
   output logic signed [CW-1:0]       out_re,
   output logic signed [CW-1:0]       out_im,
   output logic                       out_equal,
   output logic                       out_sat
);

   localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};

   // word-level reduction
   logic [LANES-1:0]     ph_b0, ph_b1;
   int                   b0_count;
   logic [1:0]           word_phase;

   logic                 first2_ff, last2_ff, eq2_ff;
   logic [2*LANES-1:0]   prod2_ff;
   logic [1:0]           phase2_ff;

   // running state of the string pair
   logic [1:0]           phase_ff, phase_in;
   logic                 eq_ff, eq_in;
   logic signed [CW-1:0] cre_ff, cre_in, cim_ff, cim_in;
   logic                 sat_ff, sat_in;

   logic signed [CW-1:0] neg_re, neg_im, rot_re, rot_im;
   logic                 ovf_re, ovf_im, rot_sat;

   logic [psp_pkg::WORD_BITS-1:0] prod3_ff;
   logic                 last3_ff, eq3_ff, sat3_ff;
   logic signed [CW-1:0] re3_ff, im3_ff;

   function automatic logic [1:0] word_phase_base(input logic [1:0] base);
      return base + phase2_ff;
   endfunction

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         ph_b0[k] = s1_phase[2*k];
         ph_b1[k] = s1_phase[2*k+1];
      end
      b0_count = $countones(ph_b0);
      // mod-4 sum: low bits xor, high bits xor plus carries out of the low bits
      word_phase = {(^ph_b1) ^ b0_count[1], ^ph_b0};
   end

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         first2_ff <= s1_first;
         last2_ff  <= s1_last;
         prod2_ff  <= s1_prod;
         phase2_ff <= word_phase;
         eq2_ff    <= ~(|s1_mismatch);
      end
   end

   always_comb begin
      if (first2_ff) begin
         phase_in = word_phase_base(2'd0);
         eq_in    = eq2_ff;
         cre_in   = coef_re;
         cim_in   = coef_im;
         sat_in   = coef_sat;
      end else begin
         phase_in = word_phase_base(phase_ff);
         eq_in    = eq_ff & eq2_ff;
         cre_in   = cre_ff;
         cim_in   = cim_ff;
         sat_in   = sat_ff;
      end

      ovf_re = (cre_in == MIN_C);
      ovf_im = (cim_in == MIN_C);
      neg_re = ovf_re ? MAX_C : -cre_in;
      neg_im = ovf_im ? MAX_C : -cim_in;

      unique case (phase_in)
         2'd1: begin
            rot_re  = neg_im;
            rot_im  = cre_in;
            rot_sat = ovf_im;
         end
         2'd2: begin
            rot_re  = neg_re;
            rot_im  = neg_im;
            rot_sat = ovf_re | ovf_im;
         end
         2'd3: begin
            rot_re  = cim_in;
            rot_im  = neg_re;
            rot_sat = ovf_re;
         end
         default: begin
            rot_re  = cre_in;
            rot_im  = cim_in;
            rot_sat = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         eq_ff    <= 1'b1;
         cre_ff   <= '0;
         cim_ff   <= '0;
         sat_ff   <= 1'b0;
      end else if (ctl.load3) begin
         if (last2_ff) begin
            phase_ff <= 2'd0;
            eq_ff    <= 1'b1;
            cre_ff   <= '0;
            cim_ff   <= '0;
            sat_ff   <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            eq_ff    <= eq_in;
            cre_ff   <= cre_in;
            cim_ff   <= cim_in;
            sat_ff   <= sat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         prod3_ff <= psp_pkg::WORD_BITS'(prod2_ff);
         last3_ff <= last2_ff;
         re3_ff   <= last2_ff ? rot_re : '0;
         im3_ff   <= last2_ff ? rot_im : '0;
         eq3_ff   <= last2_ff & eq_in;
         sat3_ff  <= last2_ff & (sat_in | rot_sat);
      end
   end

   assign out_prod  = prod3_ff;
   assign out_last  = last3_ff;
   assign out_re    = re3_ff;
   assign out_im    = im3_ff;
   assign out_equal = eq3_ff;
   assign out_sat   = sat3_ff;

endmodule

// ----- sv/pauli_string_product_phase.sv -----
// Pauli string product with phase. Takes one request per clock unless back-pressure from the
// response side stalls the pipeline, and delivers one response per request, in order. The three
// stages are the lane lookup with the coefficient partial products, the phase reduction with
// rounding and clipping of the coefficient product, and the running string state with the i^phase
// rotation feeding the response register. A stage takes new data when empty or when its
// contents move on, so empty stages fill while a response waits. Unused lanes above LANES read
// and return identity. Depends on psp_pkg, psp_lane, psp_cmul and psp_merge.
module pauli_string_product_phase #(
   parameter int LANES      = 32,
   parameter int COEF_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // left_word, right_word, left_coef_re, left_coef_im, right_coef_re, right_coef_im, zero pad
   input  logic [((128+4*COEF_WIDTH+7)/8)*8-1:0] req_tdata,
   // first_word
   input  logic req_tuser,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // product_word, product_re, product_im, zero pad
   output logic [((64+2*COEF_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // strings_equal, coef_saturated
   output logic [1:0] rsp_tuser,
   output logic rsp_tlast
);

   localparam int CW    = COEF_WIDTH;
   localparam int WB    = psp_pkg::WORD_BITS;
   localparam int RSP_W = ((64 + 2*CW + 7) / 8) * 8;
   localparam logic [WB-1:0] UNUSED_MASK = ~({WB{1'b1}} >> (WB - 2*LANES));

   psp_pkg::pipe_ctl_type ctl;
   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   logic [WB-1:0]       left_word, right_word;
   logic [2*LANES-1:0]  lane_prod, lane_phase;
   logic [LANES-1:0]    lane_mis;
   logic [2*LANES-1:0]  prod1_ff, phase1_ff;
   logic [LANES-1:0]    mis1_ff;
   logic                first1_ff, last1_ff;

   logic signed [CW-1:0] coef_re, coef_im;
   logic                 coef_sat;
   logic [WB-1:0]        out_prod;
   logic signed [CW-1:0] out_re, out_im;
   logic                 out_last, out_equal, out_sat;

   // stage handshake: a stage takes new data when empty or when its contents move on
   assign adv3 = !v3_ff || rsp_tready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;
   assign ctl.load1 = req_tvalid && adv1;
   assign ctl.load2 = v1_ff && adv2;
   assign ctl.load3 = v2_ff && adv3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_tvalid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   assign left_word  = req_tdata[0 +: WB];
   assign right_word = req_tdata[WB +: WB];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      psp_lane u_lane (
         .left_code  (left_word[2*k +: 2]),
         .right_code (right_word[2*k +: 2]),
         .prod_code  (lane_prod[2*k +: 2]),
         .phase      (lane_phase[2*k +: 2]),
         .mismatch   (lane_mis[k])
      );
   end

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         prod1_ff  <= lane_prod;
         phase1_ff <= lane_phase;
         mis1_ff   <= lane_mis;
         first1_ff <= req_tuser;
         last1_ff  <= req_tlast;
      end
   end

   psp_cmul #(.CW(CW)) u_cmul (
      .clock    (clock),
      .ctl      (ctl),
      .a_re     (req_tdata[2*WB +: CW]),
      .a_im     (req_tdata[2*WB+CW +: CW]),
      .b_re     (req_tdata[2*WB+2*CW +: CW]),
      .b_im     (req_tdata[2*WB+3*CW +: CW]),
      .prod_re  (coef_re),
      .prod_im  (coef_im),
      .prod_sat (coef_sat)
   );

   psp_merge #(.LANES(LANES), .CW(CW)) u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .s1_first    (first1_ff),
      .s1_last     (last1_ff),
      .s1_prod     (prod1_ff),
      .s1_phase    (phase1_ff),
      .s1_mismatch (mis1_ff),
      .coef_re     (coef_re),
      .coef_im     (coef_im),
      .coef_sat    (coef_sat),
      .out_prod    (out_prod),
      .out_last    (out_last),
      .out_re      (out_re),
      .out_im      (out_im),
      .out_equal   (out_equal),
      .out_sat     (out_sat)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = RSP_W'({out_im, out_re, out_prod});
   assign rsp_tuser  = {out_sat, out_equal};
   assign rsp_tlast  = out_last;

   // coefficient fields and flags stay zero on words that do not end a string
   a_zero_unless_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (out_re == '0) && (out_im == '0) && (rsp_tuser == 2'b00))
      else $error("coefficient fields set on a non-final response");

   // lanes above LANES always return identity
   a_unused_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_prod & UNUSED_MASK) == '0))
      else $error("unused lane returned a non-identity code");

   // an empty pipeline never holds off a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v1_ff && !v2_ff && !v3_ff |-> req_tready)
      else $error("empty pipeline not ready for a request");

   // a request accepted into an empty pipeline is not lost: it is offered as a response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ctl.load1 && !v1_ff && !v2_ff && !v3_ff |-> ##3 rsp_tvalid)
      else $error("request lost in the pipeline");

endmodule
